### rtl/core/fru_pkg.sv
// Shared types and constants for the Fresnel refraction unit.
// No dependencies; imported by the top level and its port checker.
package fru_pkg;

	// Default fraction bits of the direction vectors
	localparam int VEC_FRAC_BITS_DEF = 14;

	// Number of register stages from input to output register
	localparam int PIPE_DEPTH = 104;

	// Reflectance code for total reflection (1.0 in Q1.15)
	localparam logic [15:0] REFL_ONE = 16'h8000;

	// Index of refraction 1.0 in Q2.12
	localparam logic [13:0] IOR_ONE = 14'd4096;

	// 1.0 in Q.30
	localparam logic [30:0] ONE30 = 31'h4000_0000;

	// Everything an item carries down the pipeline; each stage fills its part
	typedef struct packed {
		logic [2:0][15:0] iv;
		logic [2:0][15:0] nv;
		logic [2:0]       ineg;
		logic [13:0]      n;
		logic [2:0][31:0] prod;
		logic             leaving;
		logic             tir;
		logic [13:0]      a;
		logic [13:0]      b;
		logic [30:0]      c;
		logic [27:0]      aa;
		logic [27:0]      bb;
		logic [60:0]      c2;
		logic [30:0]      s2;
		logic [58:0]      lhs;
		logic [27:0]      d1rem;
		logic [29:0]      d1q;
		logic [30:0]      ct2;
		logic [32:0]      sqrem;
		logic [30:0]      root;
		logic [3:0][13:0] bdrem;
		logic [3:0][59:0] bdq;
		logic [3:0][44:0] mp;
		logic [1:0][45:0] num;
		logic [1:0][45:0] den;
		logic [1:0][31:0] nden;
		logic [1:0][31:0] rdrem;
		logic [1:0][30:0] rdq;
		logic [1:0][30:0] rsq;
		logic [45:0]      g;
		logic [2:0][61:0] gn;
		logic [2:0][62:0] t;
		logic [2:0][15:0] comp;
		logic [15:0]      refl;
		logic             rv;
	} pipe_t;

endpackage

### rtl/core/fresnel_refraction_unit_top.sv
// Fresnel reflectance and Snell refraction for one ray hit per cycle while the output does not stall.
// Depends on fru_pkg (pipe_t, stage count, fixed-point constants).
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+-----------------------
//   in      | in_valid in_ready inc_* nrm_* index_of_.. | one ray-hit request
//   out     | out_valid out_ready refr_* reflectance .. | one result per request
//
// The pipeline has PIPE_DEPTH stages; one request enters every cycle while it is not stalled.
// The depth is set by the 30-step division by eta_t^2, the 31-step square root
// and the 31-step amplitude ratio division in series, one quotient or root bit
// per stage; the 60-step division by eta_t runs beside them.
// The whole pipeline advances together: it holds only while the output register
// is full and out_ready is low, so a stall drops and repeats nothing.
// Reset clears the stage valid bits only; payload registers are not reset.
module fresnel_refraction_unit_top
	import fru_pkg::*;
#(
	parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] inc_x,
	input  logic signed [15:0] inc_y,
	input  logic signed [15:0] inc_z,
	input  logic signed [15:0] nrm_x,
	input  logic signed [15:0] nrm_y,
	input  logic signed [15:0] nrm_z,
	input  logic        [13:0] index_of_refraction,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] refr_x,
	output logic signed [15:0] refr_y,
	output logic signed [15:0] refr_z,
	output logic        [15:0] reflectance,
	output logic               refraction_valid
);

	// Stage map
	localparam int ST_MUL    = 1;   // component products of the dot product
	localparam int ST_DOT    = 2;   // cosine, direction of travel, index swap
	localparam int ST_SQ     = 3;   // cos^2, eta^2, dividend setup for /b
	localparam int ST_SIN    = 4;   // sin^2
	localparam int ST_LHS    = 5;   // eta_i^2 * sin^2
	localparam int ST_TIR    = 6;   // total reflection test, divider setup
	localparam int D1_FIRST  = 7;   // lhs / eta_t^2, 30 steps
	localparam int D1_LAST   = 36;
	localparam int ST_CT2    = 37;  // cos_t^2
	localparam int SQ_FIRST  = 38;  // square root, 31 steps
	localparam int SQ_LAST   = 68;
	localparam int BD_FIRST  = 4;   // four dividends over eta_t, 60 steps
	localparam int BD_LAST   = 63;
	localparam int ST_AMP    = 69;  // amplitude products, g
	localparam int ST_DIFF   = 70;  // ratio operands, g*s*n
	localparam int ST_NORM   = 71;  // operand normalize, direction sum
	localparam int ST_COMP   = 72;  // scale and saturate direction
	localparam int RD_FIRST  = 72;  // amplitude ratios, 31 steps
	localparam int RD_LAST   = 102;
	localparam int ST_RSQ    = 103; // squared ratios
	localparam int ST_REFL   = 104; // reflectance and output gating

	localparam int SHR = (2 * VEC_FRAC_BITS >= 30) ? 2 * VEC_FRAC_BITS - 30 : 0;
	localparam int SHL = (2 * VEC_FRAC_BITS < 30) ? 30 - 2 * VEC_FRAC_BITS : 0;
	localparam logic [63:0] LIM   = 64'd1 << (2 * VEC_FRAC_BITS);
	localparam logic [61:0] ONE60 = 62'd1 << 60;

	pipe_t                 in_w;
	pipe_t                 pl_d [1:PIPE_DEPTH];
	pipe_t                 pl_s [1:PIPE_DEPTH];
	logic [PIPE_DEPTH:1]   vld_s;
	logic                  en;

	// Advance unless a finished result sits unclaimed in the output register
	assign en       = !vld_s[PIPE_DEPTH] || out_ready;
	assign in_ready = en;

	always_comb begin
		in_w       = '0;
		in_w.iv[0] = inc_x;
		in_w.iv[1] = inc_y;
		in_w.iv[2] = inc_z;
		in_w.nv[0] = nrm_x;
		in_w.nv[1] = nrm_y;
		in_w.nv[2] = nrm_z;
		in_w.n     = index_of_refraction;
	end

	for (genvar k = 1; k <= PIPE_DEPTH; k++) begin : g_stage
		localparam int SQ_IDX = (k >= SQ_FIRST && k <= SQ_LAST) ? k - SQ_FIRST : 0;
		pipe_t prev;
		pipe_t nxt;

		if (k == 1) begin : g_head
			assign prev = in_w;
		end else begin : g_link
			assign prev = pl_s[k-1];
		end

		always_comb begin : p_work
			logic signed [31:0] p;
			logic signed [33:0] dot;
			logic        [33:0] mabs;
			logic        [63:0] m64;
			logic        [63:0] c64;
			logic               lv;
			logic        [15:0] av;
			logic        [29:0] mag;
			logic        [44:0] acw;
			logic        [61:0] dif;
			logic        [14:0] t4;
			logic        [28:0] t1;
			logic        [61:0] xs;
			logic        [34:0] t2;
			logic        [32:0] trial;
			logic signed [61:0] pr;
			logic        [3:0]  sh;
			logic        [31:0] nn;
			logic signed [62:0] qv;
			logic signed [62:0] tv;
			logic signed [32:0] rq;
			logic        [32:0] t3;
			logic        [30:0] rr;
			logic        [61:0] sq;
			logic        [16:0] rsum;
			logic               ge;

			nxt = prev;

			if (k == ST_MUL) begin
				for (int j = 0; j < 3; j++) begin
					p = $signed(prev.iv[j]) * $signed(prev.nv[j]);
					nxt.prod[j] = p;
				end
				// A zero index behaves as the smallest code
				if (prev.n == '0) nxt.n = 14'd1;
			end

			if (k == ST_DOT) begin
				dot = $signed(prev.prod[0]) + $signed(prev.prod[1]) + $signed(prev.prod[2]);
				lv = dot > 34'sd0;
				mabs = dot[33] ? 34'(-dot) : 34'(dot);
				m64 = 64'(mabs);
				if (m64 > LIM) m64 = LIM;
				c64 = (m64 >> SHR) << SHL;
				nxt.c = c64[30:0];
				nxt.leaving = lv;
				// Leaving the material swaps the indices
				nxt.a = lv ? prev.n : IOR_ONE;
				nxt.b = lv ? IOR_ONE : prev.n;
			end

			if (k == ST_SQ) begin
				nxt.c2 = prev.c * prev.c;
				nxt.aa = prev.a * prev.a;
				nxt.bb = prev.b * prev.b;
				for (int j = 0; j < 3; j++) begin
					av = prev.iv[j][15] ? 16'(-prev.iv[j]) : prev.iv[j];
					mag = prev.a * av;
					nxt.bdq[j] = {mag, 30'b0};
					nxt.ineg[j] = prev.iv[j][15];
				end
				acw = prev.a * prev.c;
				nxt.bdq[3] = 60'(acw);
				nxt.bdrem = '0;
			end

			// Restoring division by eta_t: dividend bits shift out as quotient bits enter
			if (k >= BD_FIRST && k <= BD_LAST) begin
				for (int q = 0; q < 4; q++) begin
					t4 = {prev.bdrem[q], prev.bdq[q][59]};
					ge = t4 >= {1'b0, prev.b};
					nxt.bdrem[q] = ge ? 14'(t4 - {1'b0, prev.b}) : t4[13:0];
					nxt.bdq[q] = {prev.bdq[q][58:0], ge};
				end
			end

			if (k == ST_SIN) begin
				dif = ONE60 - 62'(prev.c2);
				nxt.s2 = dif[60:30];
			end

			if (k == ST_LHS) begin
				nxt.lhs = prev.aa * prev.s2;
			end

			if (k == ST_TIR) begin
				nxt.tir = prev.lhs >= {1'b0, prev.bb, 30'b0};
				nxt.d1rem = prev.lhs[57:30];
				nxt.d1q = prev.lhs[29:0];
			end

			if (k >= D1_FIRST && k <= D1_LAST) begin
				t1 = {prev.d1rem, prev.d1q[29]};
				ge = t1 >= {1'b0, prev.bb};
				nxt.d1rem = ge ? 28'(t1 - {1'b0, prev.bb}) : t1[27:0];
				nxt.d1q = {prev.d1q[28:0], ge};
			end

			if (k == ST_CT2) begin
				nxt.ct2 = ONE30 - 31'(prev.d1q);
				nxt.sqrem = '0;
				nxt.root = '0;
			end

			// One root bit per stage from the radicand cos_t^2 << 30
			if (k >= SQ_FIRST && k <= SQ_LAST) begin
				xs = {1'b0, prev.ct2, 30'b0};
				t2 = {prev.sqrem, xs[61-2*SQ_IDX -: 2]};
				trial = {prev.root, 2'b01};
				ge = t2 >= 35'(trial);
				nxt.sqrem = ge ? 33'(t2 - 35'(trial)) : t2[32:0];
				nxt.root = {prev.root[29:0], ge};
			end

			if (k == ST_AMP) begin
				nxt.mp[0] = prev.b * prev.c;
				nxt.mp[1] = prev.a * prev.root;
				nxt.mp[2] = prev.a * prev.c;
				nxt.mp[3] = prev.b * prev.root;
				nxt.g = $signed({1'b0, prev.bdq[3][44:0]}) - $signed({15'b0, prev.root});
			end

			if (k == ST_DIFF) begin
				for (int i = 0; i < 2; i++) begin
					nxt.num[i] = (prev.mp[2*i] >= prev.mp[2*i+1]) ?
						prev.mp[2*i] - prev.mp[2*i+1] : prev.mp[2*i+1] - prev.mp[2*i];
					nxt.den[i] = prev.mp[2*i] + prev.mp[2*i+1];
				end
				for (int j = 0; j < 3; j++) begin
					pr = $signed(prev.g) * $signed(prev.nv[j]);
					// Leaving the material flips the normal
					nxt.gn[j] = prev.leaving ? -pr : pr;
				end
			end

			if (k == ST_NORM) begin
				for (int i = 0; i < 2; i++) begin
					sh = '0;
					for (int s = 0; s < 14; s++) begin
						if (prev.den[i][32+s]) sh = 4'(s + 1);
					end
					nxt.nden[i] = 32'(prev.den[i] >> sh);
					nn = 32'(prev.num[i] >> sh);
					nxt.rdrem[i] = {1'b0, nn[31:1]};
					nxt.rdq[i] = {nn[0], 30'b0};
				end
				for (int j = 0; j < 3; j++) begin
					qv = $signed({3'b0, prev.bdq[j]});
					if (prev.ineg[j]) qv = -qv;
					nxt.t[j] = qv + $signed(prev.gn[j]);
				end
			end

			if (k == ST_COMP) begin
				for (int j = 0; j < 3; j++) begin
					tv = $signed(prev.t[j]);
					// Round toward zero on the shift
					if (tv < 63'sd0) tv = tv + 63'sd1073741823;
					rq = 33'(tv >>> 30);
					if (rq > 33'sd32767) nxt.comp[j] = 16'h7FFF;
					else if (rq < -33'sd32768) nxt.comp[j] = 16'h8000;
					else nxt.comp[j] = rq[15:0];
				end
			end

			if (k >= RD_FIRST && k <= RD_LAST) begin
				for (int i = 0; i < 2; i++) begin
					t3 = {prev.rdrem[i], prev.rdq[i][30]};
					ge = t3 >= {1'b0, prev.nden[i]};
					nxt.rdrem[i] = ge ? 32'(t3 - {1'b0, prev.nden[i]}) : t3[31:0];
					nxt.rdq[i] = {prev.rdq[i][29:0], ge};
				end
			end

			if (k == ST_RSQ) begin
				for (int i = 0; i < 2; i++) begin
					rr = (prev.rdq[i] > ONE30) ? ONE30 : prev.rdq[i];
					sq = rr * rr;
					nxt.rsq[i] = sq[60:30];
				end
			end

			if (k == ST_REFL) begin
				rsum = 17'((32'(prev.rsq[0]) + 32'(prev.rsq[1])) >> 16);
				nxt.refl = (rsum > 17'(REFL_ONE)) ? REFL_ONE : rsum[15:0];
				if (prev.tir) nxt.refl = REFL_ONE;
				nxt.rv = !prev.tir && (nxt.refl < REFL_ONE);
				// Drop the direction when no refracted ray exists
				if (!nxt.rv) nxt.comp = '0;
			end
		end

		assign pl_d[k] = nxt;
	end

	// Stage valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_DEPTH-1:1], in_valid};
		end
	end

	// Payload registers hold on a stall
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= PIPE_DEPTH; k++) pl_s[k] <= pl_d[k];
		end
	end

	assign out_valid        = vld_s[PIPE_DEPTH];
	assign refr_x           = pl_s[PIPE_DEPTH].comp[0];
	assign refr_y           = pl_s[PIPE_DEPTH].comp[1];
	assign refr_z           = pl_s[PIPE_DEPTH].comp[2];
	assign reflectance      = pl_s[PIPE_DEPTH].refl;
	assign refraction_valid = pl_s[PIPE_DEPTH].rv;

endmodule

### rtl/core/fru_chk.sv
// Port-level checker for the Fresnel refraction unit, bound to the top level.
// Depends on fru_pkg (REFL_ONE).
module fru_chk
	import fru_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [15:0] inc_x,
	input logic signed [15:0] inc_y,
	input logic signed [15:0] inc_z,
	input logic signed [15:0] nrm_x,
	input logic signed [15:0] nrm_y,
	input logic signed [15:0] nrm_z,
	input logic        [13:0] index_of_refraction,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] refr_x,
	input logic signed [15:0] refr_y,
	input logic signed [15:0] refr_z,
	input logic        [15:0] reflectance,
	input logic               refraction_valid
);

	// A refracted ray only comes with partial reflection
	a_valid_refl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && refraction_valid |-> reflectance < REFL_ONE)
		else $error("refracted ray reported with total reflection");

	// No refracted ray: zero direction and full reflection
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !refraction_valid |-> refr_x == 16'sd0 && refr_y == 16'sd0 &&
			refr_z == 16'sd0 && reflectance == REFL_ONE)
		else $error("missing refraction without zero direction and full reflection");

	// An empty output register never blocks a request
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with output register empty");

	// An unclaimed result stalls the whole pipeline
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while the pipeline stalls");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reflectance) && $stable(refr_x))
		else $error("stalled result changed");

endmodule

bind fresnel_refraction_unit_top fru_chk u_fru_chk (.*);

### bench/fresnel_refraction_unit_top_tb.sv
// Self-checking bench for fresnel_refraction_unit_top: random ray hits in, results out.
// Depends on fru_pkg (PIPE_DEPTH) and the block under test; needs no other file.
`timescale 1ns / 1ps

// One result of the block, as seen on its output ports
typedef struct {
	logic signed [15:0] rx;
	logic signed [15:0] ry;
	logic signed [15:0] rz;
	logic [15:0]        refl;
	logic               rv;
} refr_result_t;

// Keeps the predicted results in request order and compares each arriving one
class refraction_scoreboard;
	refr_result_t pending[$];
	int           errors;

	function new();
		errors = 0;
	endfunction

	static function longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x = x - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// Squared amplitude ratio num/den in Q.30, den brought below 2^32 first
	static function longint unsigned amp_sq(longint unsigned num, longint unsigned den);
		int              sh;
		longint unsigned r, dd;
		sh = 0;
		while ((den >> sh) >= (64'd1 << 32))
			sh++;
		dd = den >> sh;
		if (dd == 0)
			return 64'd1 << 30;
		r = ((num >> sh) << 30) / dd;
		if (r > (64'd1 << 30))
			r = 64'd1 << 30;
		return (r * r) >> 30;
	endfunction

	static function longint unsigned abs_diff(longint unsigned x, longint unsigned y);
		return (x >= y) ? x - y : y - x;
	endfunction

	// Predict the result of one accepted ray hit and queue it
	function void note_request(logic signed [15:0] iv[3], logic signed [15:0] nv[3],
			logic [13:0] ior);
		refr_result_t    e;
		longint          d, g, sg, t, r;
		longint unsigned n, a, b, m, c, s2, lhs, rhs, ct2, ct, rs2, rp2, rf, one30;
		bit              leaving;
		one30 = 64'd1 << 30;
		e.rx = 0;
		e.ry = 0;
		e.rz = 0;
		e.rv = 0;
		n = (ior == 0) ? 1 : ior;
		d = 0;
		for (int j = 0; j < 3; j++)
			d += longint'(iv[j]) * longint'(nv[j]);
		leaving = d > 0;
		m = (d < 0) ? longint'(-d) : d;
		if (m > (64'd1 << 28))
			m = 64'd1 << 28;
		c = m << 2;
		a = leaving ? n : 4096;
		b = leaving ? 4096 : n;
		s2 = (one30 * one30 - c * c) >> 30;
		lhs = a * a * s2;
		rhs = (b * b) << 30;
		if (lhs >= rhs) begin
			rf = 32768;
		end else begin
			ct2 = one30 - lhs / (b * b);
			ct = int_sqrt(ct2 << 30);
			rs2 = amp_sq(abs_diff(b * c, a * ct), b * c + a * ct);
			rp2 = amp_sq(abs_diff(a * c, b * ct), a * c + b * ct);
			rf = (rs2 + rp2) >> 16;
			if (rf > 32768)
				rf = 32768;
			if (rf < 32768) begin
				g = longint'((a * c) / b) - longint'(ct);
				sg = leaving ? -1 : 1;
				e.rv = 1;
				for (int j = 0; j < 3; j++) begin
					t = (longint'(a) * longint'(iv[j]) * longint'(one30)) / longint'(b)
						+ g * sg * longint'(nv[j]);
					r = t / longint'(one30);
					if (r > 32767)
						r = 32767;
					if (r < -32768)
						r = -32768;
					if (j == 0)
						e.rx = r[15:0];
					else if (j == 1)
						e.ry = r[15:0];
					else
						e.rz = r[15:0];
				end
			end
		end
		e.refl = rf[15:0];
		pending.push_back(e);
	endfunction

	function void check_result(refr_result_t got);
		refr_result_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result refl=%0d", $time, got.refl);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (got.rx !== e.rx) begin
			$display("%0t: refr_x expected %0d actual %0d", $time, e.rx, got.rx);
			errors++;
		end
		if (got.ry !== e.ry) begin
			$display("%0t: refr_y expected %0d actual %0d", $time, e.ry, got.ry);
			errors++;
		end
		if (got.rz !== e.rz) begin
			$display("%0t: refr_z expected %0d actual %0d", $time, e.rz, got.rz);
			errors++;
		end
		if (got.refl !== e.refl) begin
			$display("%0t: reflectance expected %0d actual %0d", $time, e.refl, got.refl);
			errors++;
		end
		if (got.rv !== e.rv) begin
			$display("%0t: refraction_valid expected %0d actual %0d", $time, e.rv, got.rv);
			errors++;
		end
	endfunction
endclass

module fresnel_refraction_unit_top_tb;
	import fru_pkg::*;

	localparam int NUM_RANDOM = 1080;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic signed [15:0] inc_x = 0, inc_y = 0, inc_z = 0;
	logic signed [15:0] nrm_x = 0, nrm_y = 0, nrm_z = 0;
	logic        [13:0] index_of_refraction = 14'd4096;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [15:0] refr_x, refr_y, refr_z;
	logic        [15:0] reflectance;
	logic               refraction_valid;

	refraction_scoreboard hits = new();

	int  idle_cycles = 0;
	int  sent = 0;
	bit  no_gaps = 0;       // sender runs back to back while set
	bit  hold_request = 0;  // asks the receiver for one long hold-off
	bit  hold_done = 0;

	fresnel_refraction_unit_top dut (.*);

	always #10 clk = ~clk;

	// Random gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one ray hit; hold it until the block takes it, then note it
	task automatic send_hit(logic signed [15:0] ix, iy, iz, nx, ny, nz, logic [13:0] ior);
		logic signed [15:0] iv[3];
		logic signed [15:0] nv[3];
		int                 gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		inc_x = ix; inc_y = iy; inc_z = iz;
		nrm_x = nx; nrm_y = ny; nrm_z = nz;
		index_of_refraction = ior;
		in_valid = 1;
		do
			@(posedge clk);
		while (!in_ready);
		iv = '{ix, iy, iz};
		nv = '{nx, ny, nz};
		hits.note_request(iv, nv, ior);
		sent++;
		@(negedge clk);
	endtask

	// Random unit vector in Q2.14
	task automatic unit_vec(output logic signed [15:0] x, y, z);
		real u, phi, s;
		u = ($urandom_range(0, 20000) / 10000.0) - 1.0;
		phi = $urandom_range(0, 62831) / 10000.0;
		s = $sqrt(1.0 - u * u);
		x = 16'($rtoi(s * $cos(phi) * 16384.0));
		y = 16'($rtoi(s * $sin(phi) * 16384.0));
		z = 16'($rtoi(u * 16384.0));
	endtask

	// Random hit: mostly unit vectors with a plausible index, some raw noise
	task automatic send_random_hit();
		logic signed [15:0] ix, iy, iz, nx, ny, nz;
		logic [13:0]        ior;
		int                 kind;
		kind = $urandom_range(0, 99);
		unit_vec(ix, iy, iz);
		unit_vec(nx, ny, nz);
		if (kind < 50)
			ior = 14'($urandom_range(4096, 12288));
		else
			ior = 14'($urandom_range(1024, 16383));
		if (kind >= 85) begin
			// raw fields so every input bit toggles
			ix = 16'($urandom); iy = 16'($urandom); iz = 16'($urandom);
			nx = 16'($urandom); ny = 16'($urandom); nz = 16'($urandom);
			ior = 14'($urandom);
		end
		send_hit(ix, iy, iz, nx, ny, nz, ior);
	endtask

	// Monitor: check every result the block hands over
	always @(posedge clk) begin
		refr_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.rx = refr_x;
			got.ry = refr_y;
			got.rz = refr_z;
			got.refl = reflectance;
			got.rv = refraction_valid;
			hits.check_result(got);
		end
	end

	// Watchdog: count cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver: random stalls, stretches with none, and one long hold-off
	initial begin
		int stretch;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				out_ready = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1;
			end
			stretch = $urandom_range(0, 99);
			if (stretch < 15) begin
				out_ready = 1;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else if (stretch < 20) begin
				out_ready = 0;
				repeat ($urandom_range(8, 40)) @(negedge clk);
			end else begin
				out_ready = ($urandom_range(0, 99) < 70);
			end
		end
	end

	// Stimulus
	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: normal incidence entering and leaving at both index extremes
		send_hit(-16384, 0, 0, 16384, 0, 0, 14'd4096);
		send_hit(-16384, 0, 0, 16384, 0, 0, 14'd6144);
		send_hit(16384, 0, 0, 16384, 0, 0, 14'd6144);
		send_hit(0, -16384, 0, 0, 16384, 0, 14'd16383);
		send_hit(0, 0, 16384, 0, 0, 16384, 14'd1024);
		// grazing hit: cosine exactly zero
		send_hit(16384, 0, 0, 0, 16384, 0, 14'd6144);
		// oblique exit past the critical angle: total reflection
		send_hit(11585, 0, 11585, 0, 0, 16384, 14'd6144);
		send_hit(15000, 0, 6586, 0, 0, 16384, 14'd16383);
		// oblique entry and exit under the critical angle
		send_hit(11585, 0, -11585, 0, 0, 16384, 14'd6144);
		send_hit(3000, 0, 16107, 0, 0, 16384, 14'd5000);
		// zero index, and index with every bit set
		send_hit(-16384, 0, 0, 16384, 0, 0, 14'd0);
		send_hit(8000, 0, -14298, 0, 0, 16384, 14'h3fff);
		// non-unit vectors at the field extremes, clamped cosine
		send_hit(-32768, -32768, -32768, 32767, 32767, 32767, 14'd4096);
		send_hit(32767, 32767, 32767, 32767, 32767, 32767, 14'd1024);
		send_hit(-32768, 32767, -32768, -32768, 32767, -32768, 14'd16383);
		send_hit(32767, -32768, 0, 32767, -32768, 0, 14'd2048);
		// saturating refraction output, then all-zero vectors
		send_hit(-32768, 32767, 0, 0, 32767, 0, 14'd1024);
		send_hit(0, 0, 0, 0, 0, 0, 14'd4096);

		for (int i = 0; i < NUM_RANDOM; i++) begin
			no_gaps = ((i / 100) % 3 == 1);
			if (i == 300) begin
				// let the receiver hold off while back to back requests fill the pipe
				hold_request = 1;
				no_gaps = 1;
			end
			if (i == 700) begin
				// pause until the pipeline has drained completely
				in_valid = 0;
				wait (hits.pending.size() == 0);
				@(negedge clk);
			end
			send_random_hit();
		end
		in_valid = 0;

		wait (hits.pending.size() == 0);
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		if (hits.errors == 0 && hits.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
